>>> design/pinhole_point_tangent_projection_defines.svh
// Assertion macros shared by the projection pipeline modules.
`ifndef PINHOLE_POINT_TANGENT_PROJECTION_DEFINES_SVH
`define PINHOLE_POINT_TANGENT_PROJECTION_DEFINES_SVH

// Antecedent implies consequent in the same cycle, checked out of reset.
`define PTP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must never be true out of reset.
`define PTP_ASSERT_NEVER(label, cond, msg) \
    `PTP_ASSERT_IMPLIES(label, cond, 1'b0, msg)

`endif

>>> design/ptp_pkg.sv
// Shared types, constants and helpers for the pinhole projection pipeline.
`timescale 1ns / 1ps

package ptp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int QUOT_BITS     = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_W         = 64;
    localparam int NUM_ROWS      = 3;
    localparam int NUM_COLS      = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_P_ROW0_COLS01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_P_ROW0_COLS23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_P_ROW1_COLS01 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_P_ROW1_COLS23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_P_ROW2_COLS01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_P_ROW2_COLS23 = 3'd5;

    typedef logic signed [WORD_W-1:0] word_t;

    // camera matrix, row major, unsigned container; read through $signed
    typedef logic [NUM_ROWS-1:0][NUM_COLS-1:0][WORD_W-1:0] mat_t;

    typedef struct packed {
        word_t point_x;
        word_t point_y;
        word_t point_z;
        word_t tangent_x;
        word_t tangent_y;
        word_t tangent_z;
    } in_item_t;

    typedef struct packed {
        word_t image_u;
        word_t image_v;
        word_t tangent_u;
        word_t tangent_v;
        logic  depth_zero;
    } result_t;

    // homogeneous point and direction after the matrix
    typedef struct packed {
        word_t a;
        word_t b;
        word_t w;
        word_t da;
        word_t db;
        word_t dw;
    } proj_t;

    // control that travels beside the numerator/denominator words
    typedef struct packed {
        logic valid;
        logic depth_zero;
        logic neg_u;
        logic neg_v;
        logic neg_tu;
        logic neg_tv;
    } num_flags_t;

    // magnitude of a signed word; the most negative word maps to 2^31
    function automatic logic [WORD_W-1:0] word_mag(input word_t x);
        logic [WORD_W-1:0] u;
        u = x;
        return u[WORD_W-1] ? (~u + WORD_W'(1)) : u;
    endfunction

endpackage

>>> design/ptp_dot.sv
// Matrix stage: six row dot products, one multiply stage and one sum/round stage.
`timescale 1ns / 1ps

module ptp_dot #(
    parameter int FRAC_BITS = ptp_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  ptp_pkg::in_item_t  in_item,
    input  ptp_pkg::mat_t      mat,
    output logic               out_valid,
    output ptp_pkg::proj_t     proj
);

    localparam int PROD_W = 2 * ptp_pkg::WORD_W;
    localparam int SUM_W  = PROD_W + 3;
    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

    ptp_pkg::word_t pt_vec [3];
    ptp_pkg::word_t tg_vec [3];

    logic signed [PROD_W-1:0] pt_prod_reg [3][3];
    logic signed [PROD_W-1:0] tg_prod_reg [3][3];
    logic                     prod_valid_reg;

    logic signed [SUM_W-1:0]  pt_sum [3];
    logic signed [SUM_W-1:0]  tg_sum [3];
    ptp_pkg::proj_t           proj_next;
    ptp_pkg::proj_t           proj_reg;
    logic                     proj_valid_reg;

    // floor after adding one half, then clamp to a word
    function automatic ptp_pkg::word_t round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] sh;
        sh = s >>> FRAC_BITS;
        if ((&sh[SUM_W-1:ptp_pkg::WORD_W-1]) || !(|sh[SUM_W-1:ptp_pkg::WORD_W-1]))
            return ptp_pkg::word_t'(sh[ptp_pkg::WORD_W-1:0]);
        else if (sh[SUM_W-1])
            return {1'b1, {(ptp_pkg::WORD_W-1){1'b0}}};
        else
            return {1'b0, {(ptp_pkg::WORD_W-1){1'b1}}};
    endfunction

    assign pt_vec[0] = in_item.point_x;
    assign pt_vec[1] = in_item.point_y;
    assign pt_vec[2] = in_item.point_z;
    assign tg_vec[0] = in_item.tangent_x;
    assign tg_vec[1] = in_item.tangent_y;
    assign tg_vec[2] = in_item.tangent_z;

    // stage 1: eighteen products
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pt_prod_reg[r][k] <= PROD_W'($signed(mat[r][k])) * PROD_W'(pt_vec[k]);
                tg_prod_reg[r][k] <= PROD_W'($signed(mat[r][k])) * PROD_W'(tg_vec[k]);
            end
        end
    end

    // stage 2: sum, translation column for the point only, round and clamp
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            pt_sum[r] = SUM_W'(pt_prod_reg[r][0]) + SUM_W'(pt_prod_reg[r][1])
                      + SUM_W'(pt_prod_reg[r][2])
                      + (SUM_W'($signed(mat[r][3])) <<< FRAC_BITS) + HALF;
            tg_sum[r] = SUM_W'(tg_prod_reg[r][0]) + SUM_W'(tg_prod_reg[r][1])
                      + SUM_W'(tg_prod_reg[r][2]) + HALF;
        end
        proj_next.a  = round_sat(pt_sum[0]);
        proj_next.b  = round_sat(pt_sum[1]);
        proj_next.w  = round_sat(pt_sum[2]);
        proj_next.da = round_sat(tg_sum[0]);
        proj_next.db = round_sat(tg_sum[1]);
        proj_next.dw = round_sat(tg_sum[2]);
    end

    always_ff @(posedge clk)
    begin
        proj_reg <= proj_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            proj_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            proj_valid_reg <= prod_valid_reg;
        end
    end

    assign out_valid = proj_valid_reg;
    assign proj      = proj_reg;

endmodule

>>> design/ptp_num.sv
// Numerator stage: quotient-rule cross products, w squared, magnitudes and signs.
`timescale 1ns / 1ps

module ptp_num #(
    parameter int FRAC_BITS = ptp_pkg::FRAC_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    input  ptp_pkg::proj_t                             proj,
    output ptp_pkg::num_flags_t                        flags,
    output logic [ptp_pkg::WORD_W+FRAC_BITS-1:0]       num_u,
    output logic [ptp_pkg::WORD_W+FRAC_BITS-1:0]       num_v,
    output logic [ptp_pkg::WORD_W-1:0]                 den_u,
    output logic [2*ptp_pkg::WORD_W+FRAC_BITS-1:0]     num_tu,
    output logic [2*ptp_pkg::WORD_W+FRAC_BITS-1:0]     num_tv,
    output logic [2*ptp_pkg::WORD_W-1:0]               den_t
);

    localparam int WW     = ptp_pkg::WORD_W;
    localparam int PROD_W = 2 * WW;

    logic [WW-1:0]             w_mag;
    ptp_pkg::num_flags_t       flags_a_next;

    logic signed [PROD_W-1:0]  wda_reg, adw_reg, wdb_reg, bdw_reg;
    logic [PROD_W-1:0]         w_sq_reg;
    logic [WW-1:0]             a_mag_reg, b_mag_reg, w_mag_reg;
    ptp_pkg::num_flags_t       flags_a_reg;

    logic signed [PROD_W:0]    nu_diff, nv_diff;
    logic [PROD_W:0]           nu_abs, nv_abs;
    ptp_pkg::num_flags_t       flags_b_next;
    ptp_pkg::num_flags_t       flags_b_reg;

    logic [WW+FRAC_BITS-1:0]   num_u_reg, num_v_reg;
    logic [WW-1:0]             den_u_reg;
    logic [PROD_W+FRAC_BITS-1:0] num_tu_reg, num_tv_reg;
    logic [PROD_W-1:0]         den_t_reg;

    // stage A: products and signs of the point quotients
    assign w_mag = ptp_pkg::word_mag(proj.w);

    always_comb
    begin
        flags_a_next            = '0;
        flags_a_next.valid      = in_valid;
        flags_a_next.depth_zero = (proj.w == '0);
        flags_a_next.neg_u      = proj.a[WW-1] ^ proj.w[WW-1];
        flags_a_next.neg_v      = proj.b[WW-1] ^ proj.w[WW-1];
    end

    always_ff @(posedge clk)
    begin
        wda_reg   <= PROD_W'(proj.w) * PROD_W'(proj.da);
        adw_reg   <= PROD_W'(proj.a) * PROD_W'(proj.dw);
        wdb_reg   <= PROD_W'(proj.w) * PROD_W'(proj.db);
        bdw_reg   <= PROD_W'(proj.b) * PROD_W'(proj.dw);
        w_sq_reg  <= PROD_W'(w_mag) * PROD_W'(w_mag);
        a_mag_reg <= ptp_pkg::word_mag(proj.a);
        b_mag_reg <= ptp_pkg::word_mag(proj.b);
        w_mag_reg <= w_mag;
    end

    // stage B: tangent numerators, magnitudes, scaled dividends
    always_comb
    begin
        nu_diff = (PROD_W+1)'(wda_reg) - (PROD_W+1)'(adw_reg);
        nv_diff = (PROD_W+1)'(wdb_reg) - (PROD_W+1)'(bdw_reg);
        nu_abs  = nu_diff[PROD_W] ? (PROD_W+1)'(-nu_diff) : nu_diff;
        nv_abs  = nv_diff[PROD_W] ? (PROD_W+1)'(-nv_diff) : nv_diff;
        flags_b_next        = flags_a_reg;
        flags_b_next.neg_tu = nu_diff[PROD_W];
        flags_b_next.neg_tv = nv_diff[PROD_W];
    end

    always_ff @(posedge clk)
    begin
        num_u_reg  <= {a_mag_reg, {FRAC_BITS{1'b0}}};
        num_v_reg  <= {b_mag_reg, {FRAC_BITS{1'b0}}};
        den_u_reg  <= w_mag_reg;
        num_tu_reg <= {nu_abs[PROD_W-1:0], {FRAC_BITS{1'b0}}};
        num_tv_reg <= {nv_abs[PROD_W-1:0], {FRAC_BITS{1'b0}}};
        den_t_reg  <= w_sq_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_a_reg <= '0;
            flags_b_reg <= '0;
        end
        else
        begin
            flags_a_reg <= flags_a_next;
            flags_b_reg <= flags_b_next;
        end
    end

    assign flags  = flags_b_reg;
    assign num_u  = num_u_reg;
    assign num_v  = num_v_reg;
    assign den_u  = den_u_reg;
    assign num_tu = num_tu_reg;
    assign num_tv = num_tv_reg;
    assign den_t  = den_t_reg;

endmodule

>>> design/ptp_div.sv
// Pipelined restoring divider: one quotient bit per stage, capped signed result.
`timescale 1ns / 1ps
`include "pinhole_point_tangent_projection_defines.svh"

module ptp_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               neg,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    output ptp_pkg::word_t     quot
);

    localparam int QB = ptp_pkg::QUOT_BITS;
    localparam int W  = (NUM_W > DEN_W + QB) ? NUM_W : DEN_W + QB;

    logic [W-1:0]      num_ext;
    logic [W-1:0]      den_top;
    logic              ovf_in;

    logic [W-1:0]      rem_reg [QB];
    logic [DEN_W-1:0]  den_reg [QB];
    logic [QB-1:0]     q_reg   [QB];
    logic              ovf_reg [QB];
    logic              neg_reg [QB];
    logic [QB-1:0]     vld_reg;

    logic [QB-1:0]     cap;
    logic [QB-1:0]     q_mag;

    // quotient of 2^QB or more always clamps; a zero divisor lands here too
    assign num_ext = W'(num);
    assign den_top = W'({den, {QB{1'b0}}});
    assign ovf_in  = (num_ext >= den_top);

    generate
        for (genvar j = 0; j < QB; j++)
        begin : g_stage
            logic [W-1:0]     rem_prev;
            logic [DEN_W-1:0] den_prev;
            logic [QB-1:0]    q_prev;
            logic             ovf_prev;
            logic             neg_prev;
            logic             vld_prev;
            logic [W-1:0]     trial;
            logic             take;

            if (j == 0)
            begin : g_first
                assign rem_prev = num_ext;
                assign den_prev = den;
                assign q_prev   = '0;
                assign ovf_prev = ovf_in;
                assign neg_prev = neg;
                assign vld_prev = in_valid;
            end
            else
            begin : g_next
                assign rem_prev = rem_reg[j-1];
                assign den_prev = den_reg[j-1];
                assign q_prev   = q_reg[j-1];
                assign ovf_prev = ovf_reg[j-1];
                assign neg_prev = neg_reg[j-1];
                assign vld_prev = vld_reg[j-1];
            end

            // trial subtract of the divisor at this bit weight
            assign trial = W'(den_prev) << (QB - 1 - j);
            assign take  = (rem_prev >= trial);

            always_ff @(posedge clk)
            begin
                rem_reg[j] <= take ? (rem_prev - trial) : rem_prev;
                den_reg[j] <= den_prev;
                q_reg[j]   <= {q_prev[QB-2:0], take};
                ovf_reg[j] <= ovf_prev;
                neg_reg[j] <= neg_prev;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[j] <= 1'b0;
                else
                    vld_reg[j] <= vld_prev;
            end
        end
    endgenerate

    // clamp to the signed word range and apply the sign
    assign cap   = neg_reg[QB-1] ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
    assign q_mag = (ovf_reg[QB-1] || (q_reg[QB-1] > cap)) ? cap : q_reg[QB-1];
    assign quot  = ptp_pkg::word_t'(neg_reg[QB-1] ? (~q_mag + QB'(1)) : q_mag);

    `PTP_ASSERT_NEVER(div_rem_below_den, vld_reg[QB-1] && !ovf_reg[QB-1] && (rem_reg[QB-1] >= W'(den_reg[QB-1])), "divider remainder not below divisor")

endmodule

>>> design/pinhole_point_tangent_projection.sv
// Top level: pinhole projection of a point and its tangent through a 3x4 matrix.
// Pipeline: 2 matrix stages, 2 numerator stages, 32 divider bit stages and 1 output
// register lie between the start edge that accepted an item and its result beat.
// Throughput: one item per cycle; busy stays low and results are never held off.
// The 32-stage divider, one quotient bit per stage, sets the depth.
// Reset clears the matrix to zero and drops every item in flight.
`timescale 1ns / 1ps
`include "pinhole_point_tangent_projection_defines.svh"

module pinhole_point_tangent_projection #(
    parameter int FRAC_BITS = ptp_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  ptp_pkg::in_item_t                 item,
    input  logic                              cfg_we,
    input  logic [ptp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptp_pkg::CFG_W-1:0]         cfg_data,
    output logic                              done,
    output ptp_pkg::result_t                  result
);

    localparam int WW      = ptp_pkg::WORD_W;
    localparam int QB      = ptp_pkg::QUOT_BITS;
    localparam int LATENCY = 5 + QB;

    logic                      accept;
    ptp_pkg::mat_t             mat_reg;
    ptp_pkg::mat_t             mat_next;

    logic                      proj_valid;
    ptp_pkg::proj_t            proj;

    ptp_pkg::num_flags_t       flags;
    logic [WW+FRAC_BITS-1:0]   num_u, num_v;
    logic [WW-1:0]             den_u;
    logic [2*WW+FRAC_BITS-1:0] num_tu, num_tv;
    logic [2*WW-1:0]           den_t;

    ptp_pkg::word_t            quot_u, quot_v, quot_tu, quot_tv;

    logic [QB-1:0]             vld_line_reg;
    logic [QB-1:0]             dz_line_reg;
    logic                      done_reg;
    ptp_pkg::result_t          result_next;
    ptp_pkg::result_t          result_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration register writes
    always_comb
    begin
        mat_next = mat_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ptp_pkg::REG_P_ROW0_COLS01: mat_next[0][1:0] = cfg_data;
                ptp_pkg::REG_P_ROW0_COLS23: mat_next[0][3:2] = cfg_data;
                ptp_pkg::REG_P_ROW1_COLS01: mat_next[1][1:0] = cfg_data;
                ptp_pkg::REG_P_ROW1_COLS23: mat_next[1][3:2] = cfg_data;
                ptp_pkg::REG_P_ROW2_COLS01: mat_next[2][1:0] = cfg_data;
                ptp_pkg::REG_P_ROW2_COLS23: mat_next[2][3:2] = cfg_data;
                default: mat_next = mat_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mat_reg <= '0;
        else
            mat_reg <= mat_next;
    end

    ptp_dot #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_item   (item),
        .mat       (mat_reg),
        .out_valid (proj_valid),
        .proj      (proj)
    );

    ptp_num #(
        .FRAC_BITS (FRAC_BITS)
    ) u_num (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (proj_valid),
        .proj     (proj),
        .flags    (flags),
        .num_u    (num_u),
        .num_v    (num_v),
        .den_u    (den_u),
        .num_tu   (num_tu),
        .num_tv   (num_tv),
        .den_t    (den_t)
    );

    // four dividers run side by side
    ptp_div #(.NUM_W(WW + FRAC_BITS), .DEN_W(WW)) u_div_u (
        .clk (clk), .rst_n (rst_n), .in_valid (flags.valid),
        .neg (flags.neg_u), .num (num_u), .den (den_u), .quot (quot_u)
    );

    ptp_div #(.NUM_W(WW + FRAC_BITS), .DEN_W(WW)) u_div_v (
        .clk (clk), .rst_n (rst_n), .in_valid (flags.valid),
        .neg (flags.neg_v), .num (num_v), .den (den_u), .quot (quot_v)
    );

    ptp_div #(.NUM_W(2 * WW + FRAC_BITS), .DEN_W(2 * WW)) u_div_tu (
        .clk (clk), .rst_n (rst_n), .in_valid (flags.valid),
        .neg (flags.neg_tu), .num (num_tu), .den (den_t), .quot (quot_tu)
    );

    ptp_div #(.NUM_W(2 * WW + FRAC_BITS), .DEN_W(2 * WW)) u_div_tv (
        .clk (clk), .rst_n (rst_n), .in_valid (flags.valid),
        .neg (flags.neg_tv), .num (num_tv), .den (den_t), .quot (quot_tv)
    );

    // valid and zero-depth flag ride beside the divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_line_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            vld_line_reg <= {vld_line_reg[QB-2:0], flags.valid};
            done_reg     <= vld_line_reg[QB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        dz_line_reg <= {dz_line_reg[QB-2:0], flags.depth_zero};
    end

    // output beat register
    always_comb
    begin
        result_next.image_u    = quot_u;
        result_next.image_v    = quot_v;
        result_next.tangent_u  = quot_tu;
        result_next.tangent_v  = quot_tv;
        result_next.depth_zero = dz_line_reg[QB-1];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `PTP_ASSERT_IMPLIES(done_follows_start, done, $past(start, LATENCY), "result beat without a matching start")
    `PTP_ASSERT_IMPLIES(zero_depth_saturates, done && result.depth_zero, (result.image_u == {1'b0, {(WW-1){1'b1}}}) || (result.image_u == {1'b1, {(WW-1){1'b0}}}), "zero depth without saturated u")

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the pinhole point and tangent projection block.
`timescale 1ns / 1ps

module testbench;

    localparam int LATENCY    = 37;
    localparam int IDLE_LIMIT = 4000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    ptp_pkg::in_item_t item;
    logic     cfg_we;
    logic [ptp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ptp_pkg::CFG_W-1:0]     cfg_data;
    logic     done;
    ptp_pkg::result_t  result;

    // camera matrix as the predictor sees it
    logic signed [ptp_pkg::WORD_W-1:0] cam[ptp_pkg::NUM_ROWS][ptp_pkg::NUM_COLS];
    ptp_pkg::result_t expected_projections[$];
    int  mismatches;
    int  idle_cycles;
    bit  beat_sent;
    logic busy_s;

    pinhole_point_tangent_projection i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one matrix row dotted with a point (hom=1) or a direction (hom=0)
    function automatic ptp_pkg::word_t row_dot(int r, ptp_pkg::in_item_t it, bit hom);
        logic signed [127:0] acc;
        logic signed [127:0] m;
        logic signed [127:0] x;
        acc = 0;
        for (int k = 0; k < 3; k++)
        begin
            m = cam[r][k];
            case (k)
                0: x = hom ? it.point_x : it.tangent_x;
                1: x = hom ? it.point_y : it.tangent_y;
                default: x = hom ? it.point_z : it.tangent_z;
            endcase
            acc += m * x;
        end
        if (hom)
        begin
            m = cam[r][3];
            acc += m <<< ptp_pkg::FRAC_BITS_DEF;
        end
        acc += 128'sd1 <<< (ptp_pkg::FRAC_BITS_DEF - 1);
        acc = acc >>> ptp_pkg::FRAC_BITS_DEF;
        if (acc > 128'sd2147483647) return 32'h7fffffff;
        if (acc < -128'sd2147483648) return 32'h80000000;
        return acc[31:0];
    endfunction

    // truncated quotient (mag << FRAC) / d with a signed saturated result
    function automatic ptp_pkg::word_t fixed_quot(logic [127:0] mag, bit neg,
                                                  logic [127:0] d);
        logic [127:0] q;
        logic [127:0] cap;
        q = (mag << ptp_pkg::FRAC_BITS_DEF) / d;
        cap = neg ? 128'h80000000 : 128'h7fffffff;
        if (q > cap) q = cap;
        if (neg) q = -q;
        return q[31:0];
    endfunction

    function automatic logic [127:0] mag128(logic signed [127:0] x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic ptp_pkg::word_t sat_of(logic signed [127:0] x);
        return (x < 0) ? 32'h80000000 : 32'h7fffffff;
    endfunction

    function automatic ptp_pkg::result_t project_point(ptp_pkg::in_item_t it);
        ptp_pkg::result_t r;
        logic signed [127:0] a, b, w, da, db, dw, nu, nv;
        logic [127:0] wm;
        a  = row_dot(0, it, 1'b1);
        b  = row_dot(1, it, 1'b1);
        w  = row_dot(2, it, 1'b1);
        da = row_dot(0, it, 1'b0);
        db = row_dot(1, it, 1'b0);
        dw = row_dot(2, it, 1'b0);
        nu = w * da - a * dw;
        nv = w * db - b * dw;
        if (w == 0)
        begin
            r.depth_zero = 1'b1;
            r.image_u   = sat_of(a);
            r.image_v   = sat_of(b);
            r.tangent_u = sat_of(nu);
            r.tangent_v = sat_of(nv);
        end
        else
        begin
            wm = mag128(w);
            r.depth_zero = 1'b0;
            r.image_u   = fixed_quot(mag128(a), (a < 0) != (w < 0), wm);
            r.image_v   = fixed_quot(mag128(b), (b < 0) != (w < 0), wm);
            r.tangent_u = fixed_quot(mag128(nu), nu < 0, wm * wm);
            r.tangent_v = fixed_quot(mag128(nv), nv < 0, wm * wm);
        end
        return r;
    endfunction

    // busy as it stood before the next rising edge
    always @(negedge clk)
        busy_s <= busy;

    // result check, sampled mid-cycle
    always @(negedge clk)
    begin
        ptp_pkg::result_t want;
        if (rst_n && done)
        begin
            if (expected_projections.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, actual %h", $time, result);
                mismatches++;
            end
            else
            begin
                want = expected_projections.pop_front();
                if (result.image_u !== want.image_u)
                begin
                    $display("%0t: image_u expected %h actual %h",
                             $time, want.image_u, result.image_u);
                    mismatches++;
                end
                if (result.image_v !== want.image_v)
                begin
                    $display("%0t: image_v expected %h actual %h",
                             $time, want.image_v, result.image_v);
                    mismatches++;
                end
                if (result.tangent_u !== want.tangent_u)
                begin
                    $display("%0t: tangent_u expected %h actual %h",
                             $time, want.tangent_u, result.tangent_u);
                    mismatches++;
                end
                if (result.tangent_v !== want.tangent_v)
                begin
                    $display("%0t: tangent_v expected %h actual %h",
                             $time, want.tangent_v, result.tangent_v);
                    mismatches++;
                end
                if (result.depth_zero !== want.depth_zero)
                begin
                    $display("%0t: depth_zero expected %b actual %b",
                             $time, want.depth_zero, result.depth_zero);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: cycles with neither an accepted item nor a result
    always @(negedge clk)
    begin
        if (done || beat_sent)
            idle_cycles = 0;
        else
            idle_cycles++;
        beat_sent = 1'b0;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("pinhole_point_tangent_projection regression: fail");
            $finish;
        end
    end

    // send one item; start stays high afterwards so bursts run back to back
    task automatic send_item(ptp_pkg::in_item_t it);
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy_s);
        expected_projections.push_back(project_point(it));
        beat_sent = 1'b1;
    endtask

    task automatic hold_off(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // wait for the pipe to drain before touching the matrix
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        wait (expected_projections.size() == 0);
        repeat (LATENCY + 3) @(posedge clk);
    endtask

    task automatic write_reg(logic [ptp_pkg::CFG_IDX_W-1:0] idx,
                             logic [ptp_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx < 6)
        begin
            cam[idx / 2][(idx % 2) * 2]     = data[31:0];
            cam[idx / 2][(idx % 2) * 2 + 1] = data[63:32];
        end
    endtask

    task automatic load_matrix(ptp_pkg::word_t m[12]);
        write_reg(ptp_pkg::REG_P_ROW0_COLS01, {m[1], m[0]});
        write_reg(ptp_pkg::REG_P_ROW0_COLS23, {m[3], m[2]});
        write_reg(ptp_pkg::REG_P_ROW1_COLS01, {m[5], m[4]});
        write_reg(ptp_pkg::REG_P_ROW1_COLS23, {m[7], m[6]});
        write_reg(ptp_pkg::REG_P_ROW2_COLS01, {m[9], m[8]});
        write_reg(ptp_pkg::REG_P_ROW2_COLS23, {m[11], m[10]});
    endtask

    // typical intrinsics: focal lengths, principal point, row 2 = (0,0,1,0)
    task automatic load_camera();
        ptp_pkg::word_t m[12];
        foreach (m[i]) m[i] = 0;
        m[0]  = $urandom_range(32'h0640_0000, 32'h0064_0000) | ($urandom & 32'hffff);
        m[5]  = $urandom_range(32'h0640_0000, 32'h0064_0000) | ($urandom & 32'hffff);
        m[2]  = $urandom_range(32'h0280_0000, 0);
        m[6]  = $urandom_range(32'h01e0_0000, 0);
        m[10] = 32'h0001_0000;
        load_matrix(m);
    endtask

    function automatic ptp_pkg::word_t small_word();
        return $signed($urandom_range(32'h0040_0000, 0)) - 32'sh0020_0000;
    endfunction

    function automatic ptp_pkg::in_item_t random_item(int mode);
        ptp_pkg::in_item_t it;
        if (mode == 0)
            it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        else
        begin
            it.point_x   = small_word();
            it.point_y   = small_word();
            it.point_z   = ($urandom_range(7) == 0) ? 32'sd0 : small_word();
            it.tangent_x = small_word();
            it.tangent_y = small_word();
            it.tangent_z = small_word();
        end
        return it;
    endfunction

    // zero matrix after reset: every depth is zero
    task automatic test_reset_matrix();
        ptp_pkg::in_item_t it;
        it = '0;
        send_item(it);
        it = {32'h7fffffff, 32'h80000000, 32'h1, 32'hffffffff, 32'h8000, 32'h12345678};
        send_item(it);
        drain();
    endtask

    // field extremes, zero and negative depth, rounding of a tiny w
    task automatic test_directed();
        ptp_pkg::word_t ext[4];
        ptp_pkg::in_item_t it;
        ptp_pkg::word_t m[12];
        ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h00010000};
        // out-of-range index must leave the matrix alone
        write_reg(3'd6, {$urandom, $urandom});
        write_reg(3'd7, {$urandom, $urandom});
        load_camera();
        for (int i = 0; i < 4; i++)
        begin
            it = {ext[i], ext[(i + 1) % 4], ext[i], ext[(i + 2) % 4], ext[i], ext[(i + 3) % 4]};
            send_item(it);
        end
        it = {32'h00010000, 32'h00020000, 32'h0, 32'h00010000, 32'h0, 32'h00010000};
        send_item(it);
        it = {32'h00010000, 32'hfffe0000, 32'hffff0000, 32'h0, 32'h00010000, 32'hffff0000};
        send_item(it);
        it = {32'h00050000, 32'h00050000, 32'h00000001, 32'h1, 32'h1, 32'h1};
        send_item(it);
        it = {32'h00050000, 32'h00050000, 32'h00008000, 32'h1, 32'h1, 32'h1};
        send_item(it);
        it = {32'hfff00000, 32'h00100000, 32'h00000100, 32'h00100000, 32'h0, 32'h00008000};
        send_item(it);
        drain();
        // extreme matrix words
        foreach (m[i]) m[i] = (i % 2) ? 32'h80000000 : 32'h7fffffff;
        load_matrix(m);
        for (int i = 0; i < 4; i++)
        begin
            it = {6{ext[i]}};
            send_item(it);
        end
        it = {32'h00010000, 32'h00010000, 32'h00010000, 32'h0, 32'h0, 32'h0};
        send_item(it);
        drain();
    endtask

    // bursts with random gaps under one matrix setting
    task automatic random_burst(int count, int mode);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = ($urandom_range(3) == 0) ? 40 : $urandom_range(12, 1);
            for (int i = 0; i < burst && left > 0; i++, left--)
                send_item(random_item((mode == 0 || $urandom_range(9) == 0) ? 0 : 1));
            if ($urandom_range(4) != 0)
                hold_off($urandom_range(20, 1));
        end
        drain();
    endtask

    task automatic test_random();
        ptp_pkg::word_t m[12];
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph % 3)
                0: load_camera();
                1:
                begin
                    foreach (m[i]) m[i] = small_word();
                    load_matrix(m);
                end
                default:
                begin
                    foreach (m[i]) m[i] = $urandom;
                    load_matrix(m);
                end
            endcase
            random_burst(300, (ph % 3 == 2) ? 0 : 1);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        busy_s     = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        beat_sent  = 1'b0;
        foreach (cam[r, c]) cam[r][c] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_matrix();
        test_directed();
        test_random();

        drain();
        if (mismatches == 0)
            $display("pinhole_point_tangent_projection regression: pass");
        else
            $display("pinhole_point_tangent_projection regression: fail");
        $finish;
    end

endmodule

>>> pinhole_point_tangent_projection.f
+incdir+design
design/ptp_pkg.sv
design/ptp_dot.sv
design/ptp_num.sv
design/ptp_div.sv
design/pinhole_point_tangent_projection.sv
tb/sv/testbench.sv
